### rtl/core/lsam_pkg.sv
// shared types and constants for the load/store align and merge unit
package lsam_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned DataW = 64;
  localparam int unsigned WordW = 32;

  typedef enum logic [4:0] {
    OP_LB  = 5'd0,
    OP_LBU = 5'd1,
    OP_LH  = 5'd2,
    OP_LHU = 5'd3,
    OP_LW  = 5'd4,
    OP_LWU = 5'd5,
    OP_LD  = 5'd6,
    OP_SB  = 5'd7,
    OP_SH  = 5'd8,
    OP_SW  = 5'd9,
    OP_SD  = 5'd10,
    OP_LWL = 5'd11,
    OP_LWR = 5'd12,
    OP_SWL = 5'd13,
    OP_SWR = 5'd14,
    OP_LDL = 5'd15,
    OP_LDR = 5'd16,
    OP_SDL = 5'd17,
    OP_SDR = 5'd18,
    OP_LQ  = 5'd19,
    OP_SQ  = 5'd20
  } lsam_op_t;

  typedef struct packed {
    logic [4:0]        operation;
    logic [AddrW-1:0]  base_value;
    logic signed [15:0] offset;
    logic [4:0]        dest_index;
    logic [DataW-1:0]  reg_value;
    logic [DataW-1:0]  mem_value;
  } lsam_in_t;

  typedef struct packed {
    logic [AddrW-1:0] access_address;
    logic             write_back;
    logic [DataW-1:0] load_result;
    logic             store_enable;
    logic [DataW-1:0] store_data;
  } lsam_out_t;

  // merge unit result
  typedef struct packed {
    logic             is_load;
    logic             is_store;
    logic [DataW-1:0] lres;
    logic [DataW-1:0] sdata;
  } lsam_merge_t;

  localparam logic [WordW-1:0] LwlKeep  = 32'h00ff_ffff;
  localparam logic [WordW-1:0] WordOnes = 32'hffff_ffff;
  localparam logic [DataW-1:0] LdlKeep  = 64'h00ff_ffff_ffff_ffff;
  localparam logic [DataW-1:0] SdlKeep  = 64'hffff_ffff_ffff_ff00;
  localparam logic [DataW-1:0] DataOnes = 64'hffff_ffff_ffff_ffff;

endpackage

### rtl/core/lsam_merge.sv
// byte merge and extension for loads and stores
module lsam_merge (
  input  logic [4:0]                op_i,
  input  logic [2:0]                byte_i,
  input  logic [lsam_pkg::DataW-1:0] reg_i,
  input  logic [lsam_pkg::DataW-1:0] mem_i,
  output lsam_pkg::lsam_merge_t      res_o
);
  import lsam_pkg::*;

  logic [4:0]       s4;
  logic [4:0]       s4_inv;
  logic [5:0]       s4_p8;
  logic [5:0]       s8;
  logic [5:0]       s8_inv;
  logic [WordW-1:0] r32;
  logic [WordW-1:0] m32;
  logic [WordW-1:0] w;

  assign s4     = {byte_i[1:0], 3'b000};
  assign s4_inv = 5'd24 - s4;
  assign s4_p8  = {1'b0, s4} + 6'd8;
  assign s8     = {byte_i, 3'b000};
  assign s8_inv = 6'd56 - s8;
  assign r32    = reg_i[WordW-1:0];
  assign m32    = mem_i[WordW-1:0];

  always_comb begin
    res_o = '0;
    w     = '0;
    unique case (op_i)
      OP_LB: begin
        res_o.is_load = 1'b1;
        res_o.lres    = {{56{mem_i[7]}}, mem_i[7:0]};
      end
      OP_LBU: begin
        res_o.is_load = 1'b1;
        res_o.lres    = {56'd0, mem_i[7:0]};
      end
      OP_LH: begin
        res_o.is_load = 1'b1;
        res_o.lres    = {{48{mem_i[15]}}, mem_i[15:0]};
      end
      OP_LHU: begin
        res_o.is_load = 1'b1;
        res_o.lres    = {48'd0, mem_i[15:0]};
      end
      OP_LW: begin
        res_o.is_load = 1'b1;
        res_o.lres    = {{32{m32[31]}}, m32};
      end
      OP_LWU: begin
        res_o.is_load = 1'b1;
        res_o.lres    = {32'd0, m32};
      end
      OP_LD: begin
        res_o.is_load = 1'b1;
        res_o.lres    = mem_i;
      end
      OP_SB: begin
        res_o.is_store = 1'b1;
        res_o.sdata    = {56'd0, reg_i[7:0]};
      end
      OP_SH: begin
        res_o.is_store = 1'b1;
        res_o.sdata    = {48'd0, reg_i[15:0]};
      end
      OP_SW: begin
        res_o.is_store = 1'b1;
        res_o.sdata    = {32'd0, r32};
      end
      OP_SD: begin
        res_o.is_store = 1'b1;
        res_o.sdata    = reg_i;
      end
      OP_LWL: begin
        res_o.is_load = 1'b1;
        w = (r32 & (LwlKeep >> s4)) | (m32 << s4_inv);
        res_o.lres = {{32{w[31]}}, w};
      end
      OP_LWR: begin
        res_o.is_load = 1'b1;
        w = (r32 & ~(WordOnes >> s4)) | (m32 >> s4);
        // zero shift replaces the whole word, so it is sign-extended
        res_o.lres = (s4 == 5'd0) ? {{32{w[31]}}, w} : {reg_i[63:32], w};
      end
      OP_SWL: begin
        res_o.is_store = 1'b1;
        w = (r32 >> s4_inv) | (m32 & (WordOnes << s4_p8));
        res_o.sdata = {32'd0, w};
      end
      OP_SWR: begin
        res_o.is_store = 1'b1;
        w = (r32 << s4) | (m32 & ~(WordOnes << s4));
        res_o.sdata = {32'd0, w};
      end
      OP_LDL: begin
        res_o.is_load = 1'b1;
        res_o.lres    = (reg_i & (LdlKeep >> s8)) | (mem_i << s8_inv);
      end
      OP_LDR: begin
        res_o.is_load = 1'b1;
        res_o.lres    = (reg_i & ~(DataOnes >> s8)) | (mem_i >> s8);
      end
      OP_SDL: begin
        res_o.is_store = 1'b1;
        res_o.sdata    = (reg_i >> s8_inv) | (mem_i & (SdlKeep << s8));
      end
      OP_SDR: begin
        res_o.is_store = 1'b1;
        res_o.sdata    = (reg_i << s8) | (mem_i & ~(DataOnes << s8));
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

### rtl/core/mips_load_store_align_merge.sv
// load/store unit: address add, alignment, load merge and store merge
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------
//   input    | start / busy       | in_data  (lsam_in_t)
//   result   | out_valid strobe   | out_data (lsam_out_t)
//
// three register stages: address add, byte merge, output select.
// one beat enters every cycle; its result passes through the stage 1, stage 2 and output registers.
// busy is never raised because the result side cannot stall.
// synchronous active-low reset clears only the stage valid bits.
module mips_load_store_align_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lsam_pkg::lsam_in_t  in_data,
  output logic                out_valid,
  output lsam_pkg::lsam_out_t out_data
);
  import lsam_pkg::*;

  // stage 1: effective address
  logic             s1_valid_r;
  logic [4:0]       s1_op_r;
  logic [AddrW-1:0] s1_ea_r;
  logic [4:0]       s1_rt_r;
  logic [DataW-1:0] s1_reg_r;
  logic [DataW-1:0] s1_mem_r;
  logic [AddrW-1:0] s1_ea_nxt;

  // stage 2: merged data
  logic             s2_valid_r;
  logic [AddrW-1:0] s2_addr_r;
  logic [4:0]       s2_rt_r;
  lsam_merge_t      s2_res_r;
  logic [AddrW-1:0] s2_addr_nxt;
  lsam_merge_t      merge_res;

  // stage 3: output
  logic             out_valid_r;
  lsam_out_t        out_data_r;
  lsam_out_t        out_data_nxt;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign s1_ea_nxt = in_data.base_value + {{16{in_data.offset[15]}}, in_data.offset};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    s1_op_r  <= in_data.operation;
    s1_ea_r  <= s1_ea_nxt;
    s1_rt_r  <= in_data.dest_index;
    s1_reg_r <= in_data.reg_value;
    s1_mem_r <= in_data.mem_value;
  end

  lsam_merge u_merge (
    .op_i   (s1_op_r),
    .byte_i (s1_ea_r[2:0]),
    .reg_i  (s1_reg_r),
    .mem_i  (s1_mem_r),
    .res_o  (merge_res)
  );

  always_comb begin
    unique case (s1_op_r)
      OP_LWL, OP_LWR, OP_SWL, OP_SWR: s2_addr_nxt = {s1_ea_r[AddrW-1:2], 2'b00};
      OP_LDL, OP_LDR, OP_SDL, OP_SDR: s2_addr_nxt = {s1_ea_r[AddrW-1:3], 3'b000};
      OP_LQ, OP_SQ:                   s2_addr_nxt = {s1_ea_r[AddrW-1:4], 4'b0000};
      default:                        s2_addr_nxt = s1_ea_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_addr_r <= s2_addr_nxt;
    s2_rt_r   <= s1_rt_r;
    s2_res_r  <= merge_res;
  end

  always_comb begin
    out_data_nxt.access_address = s2_addr_r;
    out_data_nxt.write_back     = s2_res_r.is_load && (s2_rt_r != 5'd0);
    out_data_nxt.load_result    = s2_res_r.is_load ? s2_res_r.lres : '0;
    out_data_nxt.store_enable   = s2_res_r.is_store;
    out_data_nxt.store_data     = s2_res_r.is_store ? s2_res_r.sdata : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
